// ----- rtl/x86sop_pkg.sv -----
// ----------------------------------------------------------------------------
// x86sop_pkg
// Shared types, codes and helpers of the x86 string operation step unit.
// ----------------------------------------------------------------------------
package x86sop_pkg;

   // Address space width; pointers wrap at the smaller of this and 32 bits.
   localparam int ADDR_WIDTH = 32;
   localparam int PTR_WIDTH  = (ADDR_WIDTH < 32) ? ADDR_WIDTH : 32;
   localparam int DATA_WIDTH = 32;

   localparam int REQ_TDATA_WIDTH = 208;
   localparam int RSP_TDATA_WIDTH = 208;

   // String operation codes.
   typedef enum logic [2:0] {
      CMD_SCAS = 3'd0,
      CMD_CMPS = 3'd1,
      CMD_MOVS = 3'd2,
      CMD_STOS = 3'd3,
      CMD_LODS = 3'd4
   } cmd_type;

   // Element size codes; the unused code acts as dword.
   localparam logic [1:0] SIZE_BYTE  = 2'd0;
   localparam logic [1:0] SIZE_WORD  = 2'd1;
   localparam logic [1:0] SIZE_DWORD = 2'd2;

   // Repeat prefixes; the unused code acts as a plain repeat.
   localparam logic [1:0] REP_PLAIN = 2'd0;
   localparam logic [1:0] REP_E     = 2'd1;
   localparam logic [1:0] REP_NE    = 2'd2;

   // Bit positions in the flags field.
   localparam int FLAG_CF = 0;
   localparam int FLAG_PF = 1;
   localparam int FLAG_AF = 2;
   localparam int FLAG_ZF = 3;
   localparam int FLAG_SF = 4;
   localparam int FLAG_OF = 5;

   // Request word, last declared field in the lowest bits.
   typedef struct packed {
      logic [6:0]            pad;
      logic [DATA_WIDTH-1:0] src_mem_value;
      logic [DATA_WIDTH-1:0] dst_mem_value;
      logic [DATA_WIDTH-1:0] acc_value;
      logic [31:0]           count_in;
      logic [31:0]           src_ptr_in;
      logic [31:0]           dst_ptr_in;
      logic                  first;
      logic [1:0]            rep_mode;
      logic                  dir_down;
      logic [1:0]            size_code;
      logic [2:0]            cmd;
   } req_word_type;

   // Response word, last declared field in the lowest bits; done travels as tlast.
   typedef struct packed {
      logic [6:0]            pad;
      logic                  flags_valid;
      logic [5:0]            flags;
      logic [DATA_WIDTH-1:0] acc_out;
      logic                  acc_write;
      logic [DATA_WIDTH-1:0] write_data;
      logic [31:0]           write_addr;
      logic                  mem_write;
      logic [31:0]           count_left;
      logic [31:0]           src_ptr;
      logic [31:0]           dst_ptr;
   } rsp_word_type;

   // Mask that keeps one element of the given size.
   function automatic logic [DATA_WIDTH-1:0] elem_mask(input logic [1:0] size_code);
      logic [DATA_WIDTH-1:0] mask;
      case (size_code)
         SIZE_BYTE: mask = 32'h0000_00FF;
         SIZE_WORD: mask = 32'h0000_FFFF;
         default:   mask = 32'hFFFF_FFFF;
      endcase
      return mask;
   endfunction

   // Most significant bit of an element of the given size.
   function automatic logic elem_msb(input logic [1:0] size_code,
                                     input logic [DATA_WIDTH-1:0] value);
      logic msb;
      case (size_code)
         SIZE_BYTE: msb = value[7];
         SIZE_WORD: msb = value[15];
         default:   msb = value[31];
      endcase
      return msb;
   endfunction

endpackage

// ----- rtl/x86sop_flags.sv -----
// ----------------------------------------------------------------------------
// x86sop_flags
// Subtraction flags (a minus b) at byte, word or dword element size.
// ----------------------------------------------------------------------------
module x86sop_flags (
   input  logic [x86sop_pkg::DATA_WIDTH-1:0] a_val,
   input  logic [x86sop_pkg::DATA_WIDTH-1:0] b_val,
   input  logic [1:0]                        size_code,
   output logic [5:0]                        flags
);

   logic [x86sop_pkg::DATA_WIDTH-1:0] mask;
   logic [x86sop_pkg::DATA_WIDTH-1:0] a_m;
   logic [x86sop_pkg::DATA_WIDTH-1:0] b_m;
   logic [x86sop_pkg::DATA_WIDTH-1:0] diff;
   logic [x86sop_pkg::DATA_WIDTH-1:0] carries;
   logic [x86sop_pkg::DATA_WIDTH-1:0] ovf_bits;

   // Operands and difference are cut to the element size.
   assign mask     = x86sop_pkg::elem_mask(size_code);
   assign a_m      = a_val & mask;
   assign b_m      = b_val & mask;
   assign diff     = (a_m - b_m) & mask;
   assign carries  = a_m ^ b_m ^ diff;
   assign ovf_bits = (a_m ^ b_m) & (a_m ^ diff);

   // Parity covers the low byte only and is set when it is even.
   always_comb begin
      flags                      = '0;
      flags[x86sop_pkg::FLAG_CF] = a_m < b_m;
      flags[x86sop_pkg::FLAG_PF] = ~^diff[7:0];
      flags[x86sop_pkg::FLAG_AF] = carries[4];
      flags[x86sop_pkg::FLAG_ZF] = diff == '0;
      flags[x86sop_pkg::FLAG_SF] = x86sop_pkg::elem_msb(size_code, diff);
      flags[x86sop_pkg::FLAG_OF] = x86sop_pkg::elem_msb(size_code, ovf_bits);
   end

endmodule

// ----- rtl/x86_string_op_step_unit.sv -----
// ----------------------------------------------------------------------------
// x86_string_op_step_unit
// Steps x86 string instructions (scas, cmps, movs, stos, lods) one element
// per request word, keeping the pointers and the remaining repeat count.
//
// Usage:
//   The req_ channel carries one element step per word. A word with the
//   first bit set loads the destination pointer, source pointer and count
//   and then performs its own element step. Later words bring the memory
//   elements and the accumulator. Each request word gives exactly one
//   rsp_ word: the pointers and count after the step, the memory write, the
//   accumulator load, the compare flags, and rsp_tlast when the instruction
//   is finished (count reached zero, repe/repne test failed, or nothing to do).
//   There is one input register and one result register with the step
//   logic between them; rsp_tvalid rises when a step moves into the
//   result register. Throughput is one word per cycle while rsp_tready
//   stays high; the pointer/count state is written in the same cycle
//   that a step moves into the result register, so the next word sees it.
//   When rsp_tready is low the result register holds, the input register
//   still takes one more word, and req_tready then drops until it moves.
//   Reset clears both registers' valid bits, the pointers and the count,
//   and leaves the unit idle.
// ----------------------------------------------------------------------------
module x86_string_op_step_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // From bit 0: cmd, size_code, dir_down, rep_mode, first, dst_ptr_in,
   // src_ptr_in, count_in, acc_value, dst_mem_value, src_mem_value, zeros.
   input  logic [x86sop_pkg::REQ_TDATA_WIDTH-1:0]  req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // From bit 0: dst_ptr, src_ptr, count_left, mem_write, write_addr,
   // write_data, acc_write, acc_out, flags, flags_valid, zeros.
   output logic [x86sop_pkg::RSP_TDATA_WIDTH-1:0]  rsp_tdata,
   // done_res.
   output logic                                    rsp_tlast
);

   x86sop_pkg::req_word_type req_word_ff;
   logic                     req_valid_ff;
   logic                     req_valid_in;

   x86sop_pkg::rsp_word_type rsp_word_ff;
   x86sop_pkg::rsp_word_type rsp_word_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic                     rsp_last_ff;
   logic                     rsp_last_in;

   logic [x86sop_pkg::PTR_WIDTH-1:0] dest_ff;
   logic [x86sop_pkg::PTR_WIDTH-1:0] dest_in;
   logic [x86sop_pkg::PTR_WIDTH-1:0] source_ff;
   logic [x86sop_pkg::PTR_WIDTH-1:0] source_in;
   logic [31:0]                      remain_ff;
   logic [31:0]                      remain_in;
   logic                             running_ff;
   logic                             running_in;

   logic                             advance;
   logic [x86sop_pkg::PTR_WIDTH-1:0] cur_dest;
   logic [x86sop_pkg::PTR_WIDTH-1:0] cur_source;
   logic [31:0]                      cur_remain;
   logic                             cur_run;
   logic [x86sop_pkg::PTR_WIDTH-1:0] step_size;
   logic [x86sop_pkg::PTR_WIDTH-1:0] step_delta;
   logic [x86sop_pkg::DATA_WIDTH-1:0] mask;
   logic [x86sop_pkg::DATA_WIDTH-1:0] cmp_a;
   logic [5:0]                       cmp_flags;
   logic                             stop;

   // Handshake: the input register moves on when the result register is free.
   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign req_valid_in = (req_tvalid && req_tready) ? 1'b1 :
                         (advance ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Compare unit: scas uses the accumulator, cmps the source element.
   assign cmp_a = (req_word_ff.cmd == x86sop_pkg::CMD_SCAS) ?
                  req_word_ff.acc_value : req_word_ff.src_mem_value;

   x86sop_flags u_flags (
      .a_val     (cmp_a),
      .b_val     (req_word_ff.dst_mem_value),
      .size_code (req_word_ff.size_code),
      .flags     (cmp_flags)
   );

   assign mask = x86sop_pkg::elem_mask(req_word_ff.size_code);

   // Pointer step by element size, negated when stepping down.
   always_comb begin
      case (req_word_ff.size_code)
         x86sop_pkg::SIZE_BYTE: step_size = x86sop_pkg::PTR_WIDTH'(1);
         x86sop_pkg::SIZE_WORD: step_size = x86sop_pkg::PTR_WIDTH'(2);
         default:               step_size = x86sop_pkg::PTR_WIDTH'(4);
      endcase
      step_delta = req_word_ff.dir_down ? -step_size : step_size;
   end

   // One element step against the held or freshly loaded state.
   always_comb begin
      cur_dest   = req_word_ff.first ?
                   req_word_ff.dst_ptr_in[x86sop_pkg::PTR_WIDTH-1:0] : dest_ff;
      cur_source = req_word_ff.first ?
                   req_word_ff.src_ptr_in[x86sop_pkg::PTR_WIDTH-1:0] : source_ff;
      cur_remain = req_word_ff.first ? req_word_ff.count_in : remain_ff;
      cur_run    = req_word_ff.first || running_ff;

      rsp_word_in = '0;
      rsp_last_in = 1'b1;
      dest_in     = cur_dest;
      source_in   = cur_source;
      remain_in   = cur_remain;
      running_in  = cur_run;
      stop        = 1'b0;

      if (cur_run) begin
         if (cur_remain == '0 || req_word_ff.cmd > x86sop_pkg::CMD_LODS) begin
            running_in = 1'b0;
         end else begin
            case (req_word_ff.cmd)
               x86sop_pkg::CMD_SCAS, x86sop_pkg::CMD_CMPS: begin
                  rsp_word_in.flags       = cmp_flags;
                  rsp_word_in.flags_valid = 1'b1;
                  if (req_word_ff.rep_mode == x86sop_pkg::REP_E) begin
                     stop = !cmp_flags[x86sop_pkg::FLAG_ZF];
                  end else if (req_word_ff.rep_mode == x86sop_pkg::REP_NE) begin
                     stop = cmp_flags[x86sop_pkg::FLAG_ZF];
                  end
               end
               x86sop_pkg::CMD_MOVS: begin
                  rsp_word_in.mem_write  = 1'b1;
                  rsp_word_in.write_addr = 32'(cur_dest);
                  rsp_word_in.write_data = req_word_ff.src_mem_value & mask;
               end
               x86sop_pkg::CMD_STOS: begin
                  rsp_word_in.mem_write  = 1'b1;
                  rsp_word_in.write_addr = 32'(cur_dest);
                  rsp_word_in.write_data = req_word_ff.acc_value & mask;
               end
               x86sop_pkg::CMD_LODS: begin
                  rsp_word_in.acc_write = 1'b1;
                  rsp_word_in.acc_out   = req_word_ff.src_mem_value & mask;
               end
               default: begin
               end
            endcase

            // lods leaves the destination; cmps, movs and lods move the source.
            if (req_word_ff.cmd != x86sop_pkg::CMD_LODS) begin
               dest_in = cur_dest + step_delta;
            end
            if (req_word_ff.cmd == x86sop_pkg::CMD_CMPS ||
                req_word_ff.cmd == x86sop_pkg::CMD_MOVS ||
                req_word_ff.cmd == x86sop_pkg::CMD_LODS) begin
               source_in = cur_source + step_delta;
            end
            remain_in = cur_remain - 32'd1;

            if (remain_in == '0 || stop) begin
               running_in = 1'b0;
            end else begin
               rsp_last_in = 1'b0;
            end
         end
      end

      rsp_word_in.dst_ptr    = 32'(dest_in);
      rsp_word_in.src_ptr    = 32'(source_in);
      rsp_word_in.count_left = remain_in;
   end

   // Control and architectural state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dest_ff      <= '0;
         source_ff    <= '0;
         remain_ff    <= '0;
         running_ff   <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            dest_ff    <= dest_in;
            source_ff  <= source_in;
            remain_ff  <= remain_in;
            running_ff <= running_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         req_word_ff <= x86sop_pkg::req_word_type'(req_tdata);
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

`ifndef SYNTHESIS
   // An empty input register always takes a word.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_valid_ff |-> req_tready)
      else $error("input register empty but not ready");

   // An unfinished instruction always has count left.
   a_count_when_open: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_word_ff.count_left != '0)
      else $error("instruction open with zero count");

   // A step writes memory, loads the accumulator or compares, never two.
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $countones({rsp_word_ff.mem_write, rsp_word_ff.acc_write,
                                 rsp_word_ff.flags_valid}) <= 1)
      else $error("more than one action in one step");

   // The run state follows the done indication of each step.
   a_run_after_open: assert property (@(posedge clock) disable iff (reset)
      advance && !rsp_last_in |=> running_ff)
      else $error("unit idle after an unfinished step");

   a_idle_after_done: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_last_in |=> !running_ff)
      else $error("unit running after a finished step");
`endif

endmodule
